// ----- rtl/assert_macros.svh -----
// Assertion helpers; every use samples on clk and is masked while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every enabled clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pim_pkg.sv -----
`default_nettype none
package pim_pkg;

  localparam int DEF_RING_DEPTH       = 32;
  localparam int DEF_TICKS_PER_SECOND = 1000;

  // Input queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE_GAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_SCALE      = 2'd3;

  localparam logic [7:0]  RST_REPORT_INTERVAL  = 8'd10;
  localparam logic [15:0] RST_MIN_PULSE_GAP    = 16'd16;
  localparam logic [7:0]  RST_PULSES_PER_COUNT = 8'd10;
  localparam logic [19:0] RST_POWER_SCALE      = 20'd360000;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_PULSE  = 2'd1;
  localparam logic [1:0] CMD_SET    = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] energy_value;
  } pim_in_t;

  typedef struct packed {
    logic [15:0] power_now;
    logic [15:0] energy_count;
    logic [15:0] power_avg4;
    logic [15:0] power_avg32;
  } pim_out_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_PULSE,
    OP_SET
  } pim_op_t;

  typedef struct packed {
    pim_op_t     op;
    logic [15:0] energy_value;
  } pim_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PULSE_WR,
    ST_RPT_RD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } pim_state_t;

endpackage
`default_nettype wire

// ----- rtl/pim_div.sv -----
`default_nettype none
module pim_div
  import pim_pkg::*;
#(
  parameter int DW = 21
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [DW-1:0]      quo
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   sh;
  logic [DW:0]   diff;
  logic          ge;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    sh       = {rem_r, quo_r[DW-1]};
    diff     = sh - {1'b0, den_r};
    ge       = (sh >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : sh[DW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ----- rtl/pim_front.sv -----
`default_nettype none
module pim_front
  import pim_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire pim_in_t   in_data,
  output logic           q_valid,
  output pim_item_t      q_item,
  input  wire logic      q_pop
);

  pim_item_t          fifo_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;
  logic               push;
  logic               do_pop;
  pim_item_t          item;

  // Classify the command; the unused code is dropped here
  always_comb begin
    item.energy_value = in_data.energy_value;
    item.op           = OP_TICK;
    push              = 1'b0;
    case (in_data.cmd)
      CMD_TICK: begin
        item.op = OP_TICK;
        push    = in_valid && !in_stall;
      end
      CMD_PULSE: begin
        item.op = OP_PULSE;
        push    = in_valid && !in_stall;
      end
      CMD_SET: begin
        item.op = OP_SET;
        push    = in_valid && !in_stall;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    do_pop     = q_pop && q_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + {{Q_PTR_W{1'b0}}, push} - {{Q_PTR_W{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item;
    end
  end

  assign in_stall = (cnt_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = fifo_r[rd_ptr_r];

endmodule
`default_nettype wire

// ----- rtl/pim_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module pim_back
  import pim_pkg::*;
#(
  parameter int RING_DEPTH       = DEF_RING_DEPTH,
  parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire pim_item_t             q_item,
  output logic                       q_pop,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pim_out_t                   out_data
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int SUM_W = 16 + IDX_W;
  localparam int DW    = (SUM_W > CFG_DATA_W) ? SUM_W : CFG_DATA_W;
  localparam int THR_W = $clog2(255 * TICKS_PER_SECOND + 1);
  localparam logic [IDX_W:0] RD_EXT = (IDX_W + 1)'(RING_DEPTH);
  // Ring mean by reciprocal multiplication, exact over the whole ring sum range
  localparam int RS   = SUM_W + IDX_W;
  localparam int RM_W = SUM_W + 2;
  localparam int MP_W = SUM_W + RM_W;
  localparam logic [63:0] RECIP = ((64'd1 << RS) + 64'(RING_DEPTH - 1)) / 64'(RING_DEPTH);

  pim_state_t     state_r, state_nxt;
  logic [31:0]    ticks_r, ticks_nxt;
  logic [THR_W-1:0] rpt_ticks_r, rpt_ticks_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [15:0]    energy_r, energy_nxt;
  logic [7:0]     presc_r, presc_nxt;
  logic [IDX_W-1:0] ring_idx_r, ring_idx_nxt;
  logic [SUM_W-1:0] ring_sum_r, ring_sum_nxt;
  logic [15:0]    gap_r, gap_nxt;
  logic [7:0]     ppc_r, ppc_nxt;
  logic [19:0]    scale_r, scale_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [1:0]     sel_r, sel_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [15:0]    iv_r, iv_nxt;
  logic [15:0]    now_iv_r, now_iv_nxt;
  logic [17:0]    sum4_r, sum4_nxt;
  logic [DW-1:0]  d32_r, d32_nxt;
  logic [15:0]    pnow_r, pnow_nxt;
  logic [15:0]    pavg4_r, pavg4_nxt;
  logic [15:0]    pavg32_r, pavg32_nxt;
  pim_out_t       out_data_r, out_data_nxt;

  // Ring memory and per-entry valid bits (unwritten entries read as zero)
  logic [15:0]      ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld_r;
  logic [15:0]      rd_data_r;
  logic             rd_vld_r;
  logic [15:0]      rd_eff;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;

  logic [IDX_W-1:0] nidx;
  logic [2:0]       back_k;
  logic [IDX_W:0]   back_ext;
  logic [IDX_W-1:0] back_addr;
  logic [THR_W:0]   rpt_inc;
  logic [15:0]      iv_sat;
  logic [7:0]       presc_inc;
  logic [MP_W-1:0]  mean_prod;
  logic             div_start;
  logic             div_done;
  logic [DW-1:0]    div_num;
  logic [DW-1:0]    div_den;
  logic [DW-1:0]    div_quo;
  logic [DW-1:0]    div_res;
  logic             den_zero;
  logic             out_load;

  pim_div #(
    .DW(DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    nidx      = (ring_idx_r == IDX_W'(RING_DEPTH - 1)) ? '0 : ring_idx_r + 1'b1;
    back_k    = (state_r == ST_IDLE) ? 3'd0 : {1'b0, cnt_r} + 3'd1;
    back_ext  = {1'b0, ring_idx_r} + RD_EXT - (IDX_W + 1)'(back_k);
    if (back_ext >= RD_EXT) begin
      back_ext = back_ext - RD_EXT;
    end
    back_addr = back_ext[IDX_W-1:0];
    rd_addr   = (state_r == ST_IDLE && q_item.op == OP_PULSE) ? nidx : back_addr;
    rd_eff    = rd_vld_r ? rd_data_r : 16'd0;
    rpt_inc   = {1'b0, rpt_ticks_r} + 1'b1;
    iv_sat    = (ticks_r[31:16] != 16'd0) ? 16'hFFFF : ticks_r[15:0];
    presc_inc = presc_r + 8'd1;
    mean_prod = MP_W'(ring_sum_r) * MP_W'(RECIP[RM_W-1:0]);
  end

  // Division operands: sel 1 latest, 2 mean of four, 3 ring mean interval
  always_comb begin
    case (sel_r)
      2'd1: begin
        div_num = DW'(scale_r);
        div_den = DW'(now_iv_r);
      end
      2'd2: begin
        div_num = DW'(scale_r);
        div_den = DW'(sum4_r[17:2]);
      end
      default: begin
        div_num = DW'(scale_r);
        div_den = d32_r;
      end
    endcase
    den_zero = (div_den == '0);
    div_res  = den_zero ? '0 : div_quo;
  end

  always_comb begin
    state_nxt     = state_r;
    ticks_nxt     = ticks_r;
    rpt_ticks_nxt = rpt_ticks_r;
    thr_nxt       = thr_r;
    energy_nxt    = energy_r;
    presc_nxt     = presc_r;
    ring_idx_nxt  = ring_idx_r;
    ring_sum_nxt  = ring_sum_r;
    gap_nxt       = gap_r;
    ppc_nxt       = ppc_r;
    scale_nxt     = scale_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    iv_nxt        = iv_r;
    now_iv_nxt    = now_iv_r;
    sum4_nxt      = sum4_r;
    d32_nxt       = d32_r;
    pnow_nxt      = pnow_r;
    pavg4_nxt     = pavg4_r;
    pavg32_nxt    = pavg32_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.op)
            OP_TICK: begin
              if (ticks_r != 32'hFFFF_FFFF) begin
                ticks_nxt = ticks_r + 32'd1;
              end
              if (rpt_inc >= {1'b0, thr_r}) begin
                rpt_ticks_nxt = '0;
                cnt_nxt       = 2'd0;
                state_nxt     = ST_RPT_RD;
              end else begin
                rpt_ticks_nxt = rpt_inc[THR_W-1:0];
              end
            end
            OP_PULSE: begin
              if (ticks_r >= {16'd0, gap_r}) begin
                ticks_nxt = '0;
                if (presc_inc >= ppc_r) begin
                  presc_nxt  = 8'd0;
                  energy_nxt = energy_r + 16'd1;
                end else begin
                  presc_nxt = presc_inc;
                end
                // A zero interval leaves the ring alone
                if (iv_sat != 16'd0) begin
                  iv_nxt    = iv_sat;
                  state_nxt = ST_PULSE_WR;
                end
              end
            end
            OP_SET: begin
              energy_nxt = q_item.energy_value;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PULSE_WR: begin
        // rd_eff holds the entry being overwritten
        wr_en        = 1'b1;
        ring_idx_nxt = nidx;
        ring_sum_nxt = ring_sum_r - SUM_W'(rd_eff) + SUM_W'(iv_r);
        state_nxt    = ST_IDLE;
      end
      ST_RPT_RD: begin
        if (cnt_r == 2'd0) begin
          now_iv_nxt = rd_eff;
          sum4_nxt   = 18'(rd_eff);
        end else begin
          sum4_nxt = sum4_r + 18'(rd_eff);
        end
        if (cnt_r == 2'd3) begin
          d32_nxt   = DW'(mean_prod >> RS);
          sel_nxt   = 2'd1;
          state_nxt = ST_DIV_START;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      ST_DIV_START: begin
        if (den_zero) begin
          // Zero divisor: result is zero, skip the divider
          case (sel_r)
            2'd1:    pnow_nxt   = 16'd0;
            2'd2:    pavg4_nxt  = 16'd0;
            default: pavg32_nxt = 16'd0;
          endcase
          if (sel_r == 2'd3) begin
            state_nxt = ST_OUT;
          end else begin
            sel_nxt = sel_r + 2'd1;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (sel_r)
            2'd1:    pnow_nxt   = div_res[15:0];
            2'd2:    pavg4_nxt  = div_res[15:0];
            default: pavg32_nxt = div_res[15:0];
          endcase
          if (sel_r == 2'd3) begin
            state_nxt = ST_OUT;
          end else begin
            sel_nxt   = sel_r + 2'd1;
            state_nxt = ST_DIV_START;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load                  = 1'b1;
          out_data_nxt.power_now    = pnow_r;
          out_data_nxt.energy_count = energy_r;
          out_data_nxt.power_avg4   = pavg4_r;
          out_data_nxt.power_avg32  = pavg32_r;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_REPORT_INTERVAL: begin
          thr_nxt       = THR_W'(32'(cfg_data[7:0]) * TICKS_PER_SECOND);
          rpt_ticks_nxt = '0;
        end
        CFG_MIN_PULSE_GAP:    gap_nxt   = cfg_data[15:0];
        CFG_PULSES_PER_COUNT: ppc_nxt   = cfg_data[7:0];
        CFG_POWER_SCALE:      scale_nxt = cfg_data[19:0];
        default: begin
        end
      endcase
    end

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ticks_r     <= '0;
      rpt_ticks_r <= '0;
      thr_r       <= THR_W'(32'(RST_REPORT_INTERVAL) * TICKS_PER_SECOND);
      energy_r    <= '0;
      presc_r     <= '0;
      ring_idx_r  <= '0;
      ring_sum_r  <= '0;
      gap_r       <= RST_MIN_PULSE_GAP;
      ppc_r       <= RST_PULSES_PER_COUNT;
      scale_r     <= RST_POWER_SCALE;
      cnt_r       <= '0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
      ring_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      ticks_r     <= ticks_nxt;
      rpt_ticks_r <= rpt_ticks_nxt;
      thr_r       <= thr_nxt;
      energy_r    <= energy_nxt;
      presc_r     <= presc_nxt;
      ring_idx_r  <= ring_idx_nxt;
      ring_sum_r  <= ring_sum_nxt;
      gap_r       <= gap_nxt;
      ppc_r       <= ppc_nxt;
      scale_r     <= scale_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        ring_vld_r[nidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    iv_r       <= iv_nxt;
    now_iv_r   <= now_iv_nxt;
    sum4_r     <= sum4_nxt;
    d32_r      <= d32_nxt;
    pnow_r     <= pnow_nxt;
    pavg4_r    <= pavg4_nxt;
    pavg32_r   <= pavg32_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[nidx] <= iv_r;
    end
    rd_data_r <= ring_mem[rd_addr];
    rd_vld_r  <= ring_vld_r[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPLIES(a_div_done_in_wait, div_done, state_r == ST_DIV_WAIT, "divider done outside wait")
  `ASSERT_ALWAYS(a_ring_idx_range, {1'b0, ring_idx_r} < RD_EXT, "ring index out of range")
  `ASSERT_NEXT(a_pulse_wr_single, state_r == ST_PULSE_WR, state_r == ST_IDLE, "ring write not single")

endmodule
`default_nettype wire

// ----- rtl/pulse_interval_power_meter_core.sv -----
// Back end: sets, rejected pulses and plain ticks end in ST_IDLE; a ring write adds ST_PULSE_WR.
// Report tick: accept, 4 ring reads, 3 serial divisions of DW quotient bits each, 1 output load,
// DW = max(16 + log2 depth, 20).
// A zero divisor skips its division; all three divisions share one bit-serial divider.
// The front accepts up to 4 items ahead of the back; results wait in an output register.
// Synchronous active-low reset clears queue, counters, ring valid bits; config to defaults.
`default_nettype none
module pulse_interval_power_meter_core
  import pim_pkg::*;
#(
  parameter int RING_DEPTH       = DEF_RING_DEPTH,
  parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pim_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pim_out_t                   out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic      q_valid;
  pim_item_t q_item;
  logic      q_pop;

  pim_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pim_back #(
    .RING_DEPTH       (RING_DEPTH),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
